>>> rtl/core/sra_pkg.sv
// Shared types and constants of the segment reorder receiver.
`timescale 1ns / 1ps
package sra_pkg;

   localparam int OFF_W = 32;
   localparam int LEN_W = 10;

   // result kinds carried on rsp_tuser
   typedef enum logic [1:0] {
      RK_DELIVER = 2'd0,
      RK_ACK     = 2'd1,
      RK_FIN     = 2'd2
   } rkind_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic clear;   // drop every parked entry
      logic park;    // load the new entry into the lowest free cell
      logic take;    // release the cell that matches the expected offset
      logic purge;   // drop entries that are no longer ahead
   } cmd_type;

   // what one cell hands to its right neighbor
   typedef struct packed {
      logic             hit;    // some cell so far matches the expected offset
      logic             dup;    // some cell so far holds the new offset
      logic             free;   // some cell so far is empty
      logic [LEN_W-1:0] len;    // length of the matching cell
   } link_type;

endpackage

>>> rtl/core/sra_cell.sv
// One parked-segment cell of the reorder row.
`timescale 1ns / 1ps
module sra_cell #(
   parameter int TagWidth = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [sra_pkg::OFF_W-1:0] expected,
   input  logic [sra_pkg::OFF_W-1:0] new_off,
   input  logic [sra_pkg::LEN_W-1:0] new_len,
   input  logic [TagWidth-1:0]       new_tag,
   input  sra_pkg::cmd_type          cmd,
   input  sra_pkg::link_type         link_in,
   input  logic [TagWidth-1:0]       tag_in,
   output sra_pkg::link_type         link_out,
   output logic [TagWidth-1:0]       tag_out
);
   import sra_pkg::*;

   logic                valid_ff, valid_in;
   logic [OFF_W-1:0]    off_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [TagWidth-1:0] tag_ff;
   logic                match, ahead, park_here;
   logic [OFF_W-1:0]    gap;

   assign match     = valid_ff && (off_ff == expected);
   assign gap       = off_ff - expected;
   assign ahead     = (gap != '0) && !gap[OFF_W-1];
   assign park_here = cmd.park && !link_in.free && !valid_ff;

   assign link_out.hit  = link_in.hit | match;
   assign link_out.dup  = link_in.dup | (valid_ff && (off_ff == new_off));
   assign link_out.free = link_in.free | !valid_ff;
   assign link_out.len  = match ? len_ff : link_in.len;
   assign tag_out       = match ? tag_ff : tag_in;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (park_here) begin
         valid_in = 1'b1;
      end else if (cmd.take && match) begin
         valid_in = 1'b0;
      end else if (cmd.purge && !ahead) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (park_here) begin
         off_ff <= new_off;
         len_ff <= new_len;
         tag_ff <= new_tag;
      end
   end

endmodule

>>> rtl/core/segment_reorder_receiver_unit.sv
// Top level of the segment reorder receiver: control, result register and cell row.
`timescale 1ns / 1ps
// Channel  Direction  Fields
// req_     in         tuser: kind; tdata: seq_offset, seg_length, buffer_tag
// rsp_     out        tuser: result_kind; tdata: out_tag, out_length, ack_offset,
//                     dropped; tlast: last
//
// A segment that is stale, ahead or an end mark gives one result.
// An in-order segment yields its result, one per later released segment and a closing ack;
// the row finds one matching entry per cycle while output is free; control adds its length.
// Reset is synchronous; it empties the row and zeroes the expected offset, no clearing pass.
// A stalled result register holds the control; no transaction is taken while draining.
module segment_reorder_receiver_unit #(
   parameter int TableDepth = 16,
   parameter int MaxSegment = 1000,
   parameter int TagWidth   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [0:0]       req_tuser,   // kind
   // seq_offset[31:0], seg_length[41:32], buffer_tag, zero fill
   input  logic [((42+TagWidth+7)/8)*8-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [1:0]       rsp_tuser,   // result_kind
   // out_tag, out_length, ack_offset, dropped, zero fill
   output logic [((TagWidth+43+7)/8)*8-1:0] rsp_tdata,
   output logic             rsp_tlast
);
   import sra_pkg::*;

   localparam int RspW = ((TagWidth + 43 + 7) / 8) * 8;

   state_type           state_ff, state_in;
   logic [OFF_W-1:0]    expected_ff, expected_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   rkind_type           rsp_kind_ff, rsp_kind_in;
   logic [TagWidth-1:0] rsp_tag_ff, rsp_tag_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [OFF_W-1:0]    rsp_ack_ff, rsp_ack_in;
   logic                rsp_drop_ff, rsp_drop_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                load;

   logic                out_free, accept;
   logic                in_kind;
   logic [OFF_W-1:0]    in_off, in_dist;
   logic [LEN_W-1:0]    in_len_raw, in_len;
   logic [TagWidth-1:0] in_tag;
   logic                in_order, in_ahead;
   cmd_type             cmd;

   link_type            link [0:TableDepth];
   logic [TagWidth-1:0] tag_link [0:TableDepth];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign in_kind    = req_tuser[0];
   assign in_off     = req_tdata[OFF_W-1:0];
   assign in_len_raw = req_tdata[OFF_W+LEN_W-1:OFF_W];
   assign in_tag     = req_tdata[OFF_W+LEN_W+TagWidth-1:OFF_W+LEN_W];
   // saturate overlong segments
   assign in_len     = (32'(in_len_raw) > 32'(MaxSegment)) ? LEN_W'(MaxSegment) : in_len_raw;
   assign in_dist    = in_off - expected_ff;
   assign in_order   = (in_dist == '0);
   assign in_ahead   = !in_order && !in_dist[OFF_W-1];

   // row of cells; the lowest free cell takes a parked segment
   assign link[0]     = '0;
   assign tag_link[0] = '0;

   for (genvar g = 0; g < TableDepth; g++) begin : g_cell
      sra_cell #(
         .TagWidth(TagWidth)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .expected(expected_ff),
         .new_off (in_off),
         .new_len (in_len),
         .new_tag (in_tag),
         .cmd     (cmd),
         .link_in (link[g]),
         .tag_in  (tag_link[g]),
         .link_out(link[g+1]),
         .tag_out (tag_link[g+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !in_kind && in_order) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free && !link[TableDepth].hit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the control
   always_comb begin
      req_tready  = 1'b0;
      cmd         = '0;
      load        = 1'b0;
      expected_in = expected_ff;
      rsp_kind_in = RK_ACK;
      rsp_tag_in  = '0;
      rsp_len_in  = '0;
      rsp_ack_in  = expected_ff;
      rsp_drop_in = 1'b0;
      rsp_last_in = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            if (accept) begin
               load = 1'b1;
               if (in_kind) begin
                  // end of transfer: clear all state
                  cmd.clear   = 1'b1;
                  expected_in = '0;
                  rsp_kind_in = RK_FIN;
                  rsp_ack_in  = '0;
               end else if (in_order) begin
                  expected_in = expected_ff + OFF_W'(in_len);
                  rsp_kind_in = RK_DELIVER;
                  rsp_tag_in  = in_tag;
                  rsp_len_in  = in_len;
                  rsp_ack_in  = expected_in;
                  rsp_last_in = 1'b0;
               end else if (in_ahead) begin
                  if (link[TableDepth].dup || !link[TableDepth].free) begin
                     rsp_drop_in = 1'b1;
                  end else begin
                     cmd.park = 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               load = 1'b1;
               if (link[TableDepth].hit) begin
                  // release the lined-up entry and advance
                  cmd.take    = 1'b1;
                  expected_in = expected_ff + OFF_W'(link[TableDepth].len);
                  rsp_kind_in = RK_DELIVER;
                  rsp_tag_in  = tag_link[TableDepth];
                  rsp_len_in  = link[TableDepth].len;
                  rsp_ack_in  = expected_in;
                  rsp_last_in = 1'b0;
               end else begin
                  // close the run and drop overtaken entries
                  cmd.purge = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expected_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_tag_ff  <= rsp_tag_in;
         rsp_len_ff  <= rsp_len_in;
         rsp_ack_ff  <= rsp_ack_in;
         rsp_drop_ff <= rsp_drop_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RspW'({rsp_drop_ff, rsp_ack_ff, rsp_len_ff, rsp_tag_ff});

   a_ready_idle : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("input taken while draining");

   a_fin_clear : assert property (@(posedge clock) disable iff (reset)
      accept && in_kind |=> expected_ff == '0 && state_ff == ST_IDLE)
      else $error("end mark did not clear the expected offset");

   a_drain_end : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && out_free && !link[TableDepth].hit |=>
         state_ff == ST_IDLE && rsp_tlast && rsp_tuser == RK_ACK)
      else $error("run did not close with a final ack");

   a_fin_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == RK_FIN |-> rsp_last_ff && rsp_ack_ff == '0)
      else $error("end acknowledgment malformed");

endmodule
